[rtl/mmet_pkg.sv]
`timescale 1ns / 1ps
// mmet_pkg: shared types and constants of the multi-motor encoder tracker
// used by mmet_update and multi_motor_encoder_tracker; no dependencies
package mmet_pkg;

   localparam int MOTOR_SLOTS_DEF = 8;

   localparam int IDX_W   = 3;
   localparam int READ_W  = 13;
   localparam int DELTA_W = 14;
   localparam int TOTAL_W = 32;
   localparam int CNT_W   = 9;
   localparam int DIR_W   = 2;
   localparam int CPR_W   = 16;
   localparam int HALF_W  = 15;
   localparam int THR_W   = 13;
   localparam int DCNT_W  = 8;

   // unwrapped difference before saturation needs room for +-(8191 + 65535)
   localparam int WIDE_W  = 18;
   // tick counter before the set check can reach +-256
   localparam int CWIDE_W = CNT_W + 1;

   localparam logic signed [DELTA_W-1:0] DELTA_LIMIT = 14'sd8191;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_COUNTS_PER_REV  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WRAP_HALF       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MOVE_THRESHOLD  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_SET_COUNT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_CLEAR_COUNT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_REBASE      = 3'd5;

   localparam logic [CPR_W-1:0]  RST_COUNTS_PER_REV  = 16'd8191;
   localparam logic [HALF_W-1:0] RST_WRAP_HALF       = 15'd4096;
   localparam logic [THR_W-1:0]  RST_MOVE_THRESHOLD  = 13'd10;
   localparam logic [DCNT_W-1:0] RST_DIR_SET_COUNT   = 8'd150;
   localparam logic [DCNT_W-1:0] RST_DIR_CLEAR_COUNT = 8'd5;
   localparam logic [DCNT_W-1:0] RST_DIR_REBASE      = 8'd20;

   localparam logic ACTION_FEEDBACK = 1'b0;
   localparam logic ACTION_TICK     = 1'b1;

   localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

   typedef struct packed {
      logic [CPR_W-1:0]  counts_per_rev;
      logic [HALF_W-1:0] wrap_half;
      logic [THR_W-1:0]  move_threshold;
      logic [DCNT_W-1:0] dir_set_count;
      logic [DCNT_W-1:0] dir_clear_count;
      logic [DCNT_W-1:0] dir_rebase;
   } cfg_type;

   typedef struct packed {
      logic              action;
      logic [READ_W-1:0] reading;
      logic              zero_request;
      logic              hold_lock;
   } item_type;

   typedef struct packed {
      logic        [READ_W-1:0]  reading;
      logic signed [DELTA_W-1:0] delta;
      logic        [TOTAL_W-1:0] total;
      logic        [TOTAL_W-1:0] lock;
      logic signed [CNT_W-1:0]   counter;
      logic signed [DIR_W-1:0]   flag;
   } slot_state_type;

endpackage

[rtl/multi_motor_encoder_tracker.sv]
`timescale 1ns / 1ps
// multi_motor_encoder_tracker: per-slot encoder unwrap and direction tracking
// accepted items pass stage 1 and the response register; one item per cycle sustained
// while rsp_tready holds, set by the single slot state read-modify-write (with forwarding)
// synchronous active-high reset restores register defaults and marks all
// slots as zero through per-slot valid bits; no clearing pass is needed
// depends on mmet_pkg and mmet_update
module multi_motor_encoder_tracker
   import mmet_pkg::*;
#(
   parameter int MOTOR_SLOTS = MOTOR_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields from bit 0: motor_index, encoder_reading, zero_request, hold_lock
   input  logic [23:0]           req_tdata,
   // fields from bit 0: action
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // fields from bit 0: result_motor, pulse_delta, pulse_total, lock_target, direction
   output logic [87:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
   localparam int EXT_W  = SLOT_W + IDX_W;
   localparam int OUT_W  = IDX_W + DELTA_W + 2 * TOTAL_W + DIR_W;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counts_per_rev  <= RST_COUNTS_PER_REV;
         cfg_ff.wrap_half       <= RST_WRAP_HALF;
         cfg_ff.move_threshold  <= RST_MOVE_THRESHOLD;
         cfg_ff.dir_set_count   <= RST_DIR_SET_COUNT;
         cfg_ff.dir_clear_count <= RST_DIR_CLEAR_COUNT;
         cfg_ff.dir_rebase      <= RST_DIR_REBASE;
      end else if (csr_we) begin
         case (csr_addr)
            REG_COUNTS_PER_REV:  cfg_ff.counts_per_rev  <= csr_wdata[CPR_W-1:0];
            REG_WRAP_HALF:       cfg_ff.wrap_half       <= csr_wdata[HALF_W-1:0];
            REG_MOVE_THRESHOLD:  cfg_ff.move_threshold  <= csr_wdata[THR_W-1:0];
            REG_DIR_SET_COUNT:   cfg_ff.dir_set_count   <= csr_wdata[DCNT_W-1:0];
            REG_DIR_CLEAR_COUNT: cfg_ff.dir_clear_count <= csr_wdata[DCNT_W-1:0];
            REG_DIR_REBASE:      cfg_ff.dir_rebase      <= csr_wdata[DCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input decode
   logic [IDX_W-1:0]  req_motor;
   logic [EXT_W-1:0]  req_motor_ext;
   logic [SLOT_W-1:0] req_slot;
   logic              req_accept;
   item_type          req_item;

   assign req_motor             = req_tdata[IDX_W-1:0];
   assign req_motor_ext         = EXT_W'(req_motor);
   assign req_slot              = req_motor_ext[SLOT_W-1:0];
   assign req_item.action       = req_tuser;
   assign req_item.reading      = req_tdata[IDX_W +: READ_W];
   assign req_item.zero_request = req_tdata[IDX_W + READ_W];
   assign req_item.hold_lock    = req_tdata[IDX_W + READ_W + 1];
   assign req_accept            = req_tvalid && req_tready;

   // slot state memory and per-slot valid bits
   slot_state_type            state_mem [MOTOR_SLOTS];
   logic [MOTOR_SLOTS-1:0]    slot_vld_ff;
   slot_state_type            rd_data_ff;
   logic                      rd_vld_ff;

   // stage 1: item with its state read
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   item_type                  s1_item_ff;
   logic [IDX_W-1:0]          s1_motor_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic                      s1_in_range_ff;
   logic                      s1_adv;

   // last write, forwarded to an item whose read came before it
   logic                      fwd_vld_ff;
   logic [SLOT_W-1:0]         fwd_slot_ff;
   slot_state_type            fwd_data_ff;

   slot_state_type            s1_cur;
   slot_state_type            s1_nxt;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [OUT_W-1:0]          rsp_data_ff;

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_adv;
   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff     <= state_mem[req_slot];
         rd_vld_ff      <= slot_vld_ff[req_slot];
         s1_item_ff     <= req_item;
         s1_motor_ff    <= req_motor;
         s1_slot_ff     <= req_slot;
         s1_in_range_ff <= req_motor_ext < EXT_W'(MOTOR_SLOTS);
      end
      if (s1_adv && s1_in_range_ff) begin
         state_mem[s1_slot_ff] <= s1_nxt;
         fwd_slot_ff           <= s1_slot_ff;
         fwd_data_ff           <= s1_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff  <= '0;
         fwd_vld_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv && s1_in_range_ff) begin
            slot_vld_ff[s1_slot_ff] <= 1'b1;
            fwd_vld_ff              <= 1'b1;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      if (fwd_vld_ff && (fwd_slot_ff == s1_slot_ff)) begin
         s1_cur = fwd_data_ff;
      end else if (rd_vld_ff) begin
         s1_cur = rd_data_ff;
      end else begin
         s1_cur = '0;
      end
   end

   mmet_update u_update (
      .cfg  (cfg_ff),
      .item (s1_item_ff),
      .cur  (s1_cur),
      .nxt  (s1_nxt)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_in_range_ff) begin
            rsp_data_ff <= {s1_nxt.flag, s1_nxt.lock, s1_nxt.total, s1_nxt.delta, s1_motor_ff};
         end else begin
            rsp_data_ff <= {(OUT_W - IDX_W)'(0), s1_motor_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 88'(rsp_data_ff);

   // an item whose slot does not exist reports zero state
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (EXT_W'(rsp_tdata[IDX_W-1:0]) >= EXT_W'(MOTOR_SLOTS))
      |-> (rsp_tdata[OUT_W-1:IDX_W] == '0))
      else $error("out-of-range slot reported nonzero state");

   // saturation keeps the delta inside +-8191
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[IDX_W +: DELTA_W] != 14'h2000))
      else $error("pulse_delta outside saturation range");

   // direction is only -1, 0 or 1
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[OUT_W-1 -: DIR_W] != 2'b10))
      else $error("illegal direction code");

   // a stalled stage-1 item is never dropped or overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_accept ##1 s1_valid_ff)
      else $error("stage-1 item lost while stalled");

endmodule

[rtl/mmet_update.sv]
`timescale 1ns / 1ps
// mmet_update: next slot state for one feedback or direction tick item
// depends on mmet_pkg
module mmet_update
   import mmet_pkg::*;
(
   input  cfg_type        cfg,
   input  item_type       item,
   input  slot_state_type cur,
   output slot_state_type nxt
);

   logic signed [DELTA_W-1:0] diff;
   logic        [DELTA_W-1:0] diff_mag;
   logic signed [WIDE_W-1:0]  unwrap;
   logic signed [DELTA_W-1:0] delta_sat;
   logic        [TOTAL_W-1:0] total_sum;
   logic        [DELTA_W-1:0] last_mag;
   logic signed [CWIDE_W-1:0] cnt_step;
   logic        [CWIDE_W-1:0] cnt_mag;
   logic signed [DIR_W-1:0]   cnt_sign;
   logic signed [CWIDE_W-1:0] rebase_ext;

   always_comb begin
      diff     = $signed(DELTA_W'({1'b0, item.reading}))
               - $signed(DELTA_W'({1'b0, cur.reading}));
      diff_mag = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
      unwrap   = WIDE_W'(diff);
      if (HALF_W'(diff_mag) > cfg.wrap_half) begin
         if (diff[DELTA_W-1]) begin
            unwrap = unwrap + $signed(WIDE_W'(cfg.counts_per_rev));
         end else begin
            unwrap = unwrap - $signed(WIDE_W'(cfg.counts_per_rev));
         end
      end
      if (unwrap > WIDE_W'(DELTA_LIMIT)) begin
         delta_sat = DELTA_LIMIT;
      end else if (unwrap < -WIDE_W'(DELTA_LIMIT)) begin
         delta_sat = -DELTA_LIMIT;
      end else begin
         delta_sat = unwrap[DELTA_W-1:0];
      end
      total_sum = cur.total + TOTAL_W'(delta_sat);

      // direction tick
      last_mag = cur.delta[DELTA_W-1] ? DELTA_W'(-cur.delta) : DELTA_W'(cur.delta);
      cnt_step = CWIDE_W'(cur.counter);
      if (last_mag > DELTA_W'(cfg.move_threshold)) begin
         cnt_step = cur.delta[DELTA_W-1] ? cnt_step - CWIDE_W'(1) : cnt_step + CWIDE_W'(1);
      end else if (cnt_step > 0) begin
         cnt_step = cnt_step - CWIDE_W'(1);
      end else if (cnt_step < 0) begin
         cnt_step = cnt_step + CWIDE_W'(1);
      end
      cnt_mag    = cnt_step[CWIDE_W-1] ? CWIDE_W'(-cnt_step) : CWIDE_W'(cnt_step);
      cnt_sign   = (cnt_step > 0) ? DIR_FWD : ((cnt_step < 0) ? DIR_REV : DIR_NONE);
      rebase_ext = $signed(CWIDE_W'(cfg.dir_rebase));

      nxt = cur;
      if (item.action == ACTION_FEEDBACK) begin
         nxt.reading = item.reading;
         nxt.delta   = delta_sat;
         nxt.total   = total_sum;
         if (!item.hold_lock) begin
            nxt.lock = total_sum;
         end
         if (item.zero_request) begin
            nxt.total = '0;
            nxt.lock  = '0;
         end
      end else begin
         nxt.counter = cnt_step[CNT_W-1:0];
         if (cnt_mag >= CWIDE_W'(cfg.dir_set_count)) begin
            nxt.flag = cnt_sign;
            if (cnt_sign == DIR_FWD) begin
               nxt.counter = rebase_ext[CNT_W-1:0];
            end else if (cnt_sign == DIR_REV) begin
               nxt.counter = CNT_W'(-rebase_ext);
            end else begin
               nxt.counter = '0;
            end
         end else if (cnt_mag <= CWIDE_W'(cfg.dir_clear_count)) begin
            nxt.flag = DIR_NONE;
         end
      end
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for multi_motor_encoder_tracker; a slot-state predictor
// checks every response; random stream stalls on both sides and several register settings
// depends on mmet_pkg and the tracker rtl
module tb_top;
   import mmet_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]          motor;
      logic signed [DELTA_W-1:0] delta;
      logic [TOTAL_W-1:0]        total;
      logic [TOTAL_W-1:0]        lock;
      logic signed [DIR_W-1:0]   dir;
   } slot_report_type;

   class motor_track_sb_type;
      cfg_type         cfg;
      slot_state_type  slot_state [MOTOR_SLOTS_DEF];
      slot_report_type expected_slots [$];
      int              errors;

      function new();
         cfg.counts_per_rev  = RST_COUNTS_PER_REV;
         cfg.wrap_half       = RST_WRAP_HALF;
         cfg.move_threshold  = RST_MOVE_THRESHOLD;
         cfg.dir_set_count   = RST_DIR_SET_COUNT;
         cfg.dir_clear_count = RST_DIR_CLEAR_COUNT;
         cfg.dir_rebase      = RST_DIR_REBASE;
         foreach (slot_state[i]) slot_state[i] = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_COUNTS_PER_REV:  cfg.counts_per_rev  = val[CPR_W-1:0];
            REG_WRAP_HALF:       cfg.wrap_half       = val[HALF_W-1:0];
            REG_MOVE_THRESHOLD:  cfg.move_threshold  = val[THR_W-1:0];
            REG_DIR_SET_COUNT:   cfg.dir_set_count   = val[DCNT_W-1:0];
            REG_DIR_CLEAR_COUNT: cfg.dir_clear_count = val[DCNT_W-1:0];
            REG_DIR_REBASE:      cfg.dir_rebase      = val[DCNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int mag_of(int v);
         return (v < 0) ? -v : v;
      endfunction

      function int sign_of(int v);
         return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
      endfunction

      function int pending();
         return expected_slots.size();
      endfunction

      // apply one accepted item to the slot copy and queue the slot view it yields
      function void note_item(logic act, logic [IDX_W-1:0] m, logic [READ_W-1:0] rd,
                              logic zr, logic hl);
         slot_state_type  s;
         slot_report_type r;
         int              d;
         int              c;
         int              last_d;
         s = slot_state[m];
         if (act == ACTION_FEEDBACK) begin
            d = int'(rd) - int'(s.reading);
            if (mag_of(d) > int'(cfg.wrap_half))
               d = d - sign_of(d) * int'(cfg.counts_per_rev);
            if (d > int'(DELTA_LIMIT)) d = int'(DELTA_LIMIT);
            if (d < -int'(DELTA_LIMIT)) d = -int'(DELTA_LIMIT);
            s.reading = rd;
            s.delta   = d[DELTA_W-1:0];
            s.total   = s.total + d[TOTAL_W-1:0];
            if (!hl) s.lock = s.total;
            if (zr) begin
               s.total = '0;
               s.lock  = '0;
            end
         end else begin
            c      = int'($signed(s.counter));
            last_d = int'($signed(s.delta));
            if (mag_of(last_d) > int'(cfg.move_threshold))
               c = c + sign_of(last_d);
            else if (c > 0)
               c = c - 1;
            else if (c < 0)
               c = c + 1;
            if (mag_of(c) >= int'(cfg.dir_set_count)) begin
               s.flag = (c > 0) ? DIR_FWD : ((c < 0) ? DIR_REV : DIR_NONE);
               c = sign_of(c) * int'(cfg.dir_rebase);
            end else if (mag_of(c) <= int'(cfg.dir_clear_count)) begin
               s.flag = DIR_NONE;
            end
            s.counter = c[CNT_W-1:0];
         end
         slot_state[m] = s;
         r.motor = m;
         r.delta = s.delta;
         r.total = s.total;
         r.lock  = s.lock;
         r.dir   = s.flag;
         expected_slots.push_back(r);
      endfunction

      function void compare_field(string label, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [87:0] data);
         slot_report_type r;
         if (expected_slots.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, data);
            errors++;
            return;
         end
         r = expected_slots.pop_front();
         compare_field("result_motor", longint'(r.motor), longint'(data[2:0]));
         compare_field("pulse_delta", longint'(r.delta), longint'($signed(data[16:3])));
         compare_field("pulse_total", longint'($signed(r.total)),
                       longint'($signed(data[48:17])));
         compare_field("lock_target", longint'($signed(r.lock)),
                       longint'($signed(data[80:49])));
         compare_field("direction", longint'(r.dir), longint'($signed(data[82:81])));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [87:0]           rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   motor_track_sb_type sb = new();

   int send_calm = 0;
   int recv_calm = 0;
   int track_pos  [MOTOR_SLOTS_DEF];
   int track_step [MOTOR_SLOTS_DEF];

   multi_motor_encoder_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // idle cycles before the next item, with occasional stretches of none
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic act, input logic [IDX_W-1:0] m,
                            input logic [READ_W-1:0] rd, input logic zr, input logic hl);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, hl, zr, rd, m};
      do @(posedge clock); while (!req_tready);
      sb.note_item(act, m, rd, zr, hl);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_config(input int cpr, input int half, input int thr,
                             input int set_cnt, input int clr_cnt, input int rebase);
      quiesce();
      write_reg(REG_COUNTS_PER_REV, cpr[CSR_DATA_W-1:0]);
      write_reg(REG_WRAP_HALF, half[CSR_DATA_W-1:0]);
      write_reg(REG_MOVE_THRESHOLD, thr[CSR_DATA_W-1:0]);
      write_reg(REG_DIR_SET_COUNT, set_cnt[CSR_DATA_W-1:0]);
      write_reg(REG_DIR_CLEAR_COUNT, clr_cnt[CSR_DATA_W-1:0]);
      write_reg(REG_DIR_REBASE, rebase[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
   endtask

   // mostly steady per-motor motion so direction counters build up, some noise
   task automatic run_phase(input int n_items);
      int                k;
      int                m;
      int                focus;
      logic              act;
      logic [READ_W-1:0] rd;
      logic              zr;
      logic              hl;
      focus = $urandom_range(0, MOTOR_SLOTS_DEF - 1);
      foreach (track_step[i]) track_step[i] = $urandom_range(0, 600) - 300;
      for (k = 0; k < n_items; k++) begin
         m = ($urandom_range(0, 99) < 60) ? focus : $urandom_range(0, MOTOR_SLOTS_DEF - 1);
         if ($urandom_range(0, 39) == 0)
            track_step[m] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16000) - 8000
                                                        : $urandom_range(0, 600) - 300;
         act = ($urandom_range(0, 99) < 45) ? ACTION_TICK : ACTION_FEEDBACK;
         if (act == ACTION_FEEDBACK && $urandom_range(0, 99) < 80) begin
            track_pos[m] = track_pos[m] + track_step[m];
            rd = track_pos[m][READ_W-1:0];
         end else begin
            rd = READ_W'($urandom);
         end
         zr = ($urandom_range(0, 29) == 0);
         hl = ($urandom_range(0, 3) == 0);
         send_item(act, m[IDX_W-1:0], rd, zr, hl);
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (draw_gap(recv_calm) > 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      foreach (track_pos[i]) track_pos[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // wrap boundary, hold and zero handling at reset settings
      send_item(ACTION_FEEDBACK, 3'd0, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd0, 13'd8191, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd7, 13'd4096, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd7, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd7, 13'd4097, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd1, 13'd100, 1'b0, 1'b1);
      send_item(ACTION_FEEDBACK, 3'd1, 13'd300, 1'b1, 1'b1);
      send_item(ACTION_FEEDBACK, 3'd1, 13'd8191, 1'b1, 1'b0);
      send_item(ACTION_TICK, 3'd7, 13'd8191, 1'b1, 1'b1);
      send_item(ACTION_TICK, 3'd0, 13'd0, 1'b0, 1'b0);

      // saturated delta both ways, rebase above set count
      set_config(65535, 1, 0, 1, 0, 255);
      send_item(ACTION_FEEDBACK, 3'd2, 13'd100, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd2, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_TICK, 3'd2, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_TICK, 3'd2, 13'd0, 1'b0, 1'b0);

      // set count of zero
      set_config(8191, 4096, 8191, 0, 0, 7);
      send_item(ACTION_TICK, 3'd3, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_TICK, 3'd2, 13'd0, 1'b0, 1'b0);
      send_item(ACTION_FEEDBACK, 3'd3, 13'd8191, 1'b0, 1'b1);
      send_item(ACTION_TICK, 3'd3, 13'd0, 1'b0, 1'b0);

      set_config(8192, 4096, 10, $urandom_range(3, 12), $urandom_range(0, 2),
                 $urandom_range(0, 3));
      run_phase(160);
      set_config(1, 1, 0, 1, 0, 0);
      run_phase(160);
      set_config(65535, 32767, 8191, 255, 255, 255);
      run_phase(160);
      set_config($urandom_range(1, 65535), $urandom_range(1, 32767), $urandom_range(0, 300),
                 $urandom_range(1, 20), $urandom_range(0, 10), $urandom_range(0, 255));
      run_phase(160);
      set_config(8192, 4096, 5, 4, 2, 30);
      run_phase(160);
      set_config(8191, 4096, 10, 150, 5, 20);
      run_phase(160);

      quiesce();
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/mmet_pkg.sv
rtl/mmet_update.sv
rtl/multi_motor_encoder_tracker.sv
sim/tb_top.sv
